>>> hdl/assert_macros.svh
// assertion macros used by the rtl top level, tilt_light_sensor_fusion
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define TLSF_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define TLSF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tlsf_pkg.sv
// shared types and constants of the tilt / light fusion block
// no dependencies
package tlsf_pkg;

  localparam int APB_AW = 4;

  localparam logic [6:0]  GYRO_WEIGHT_RST = 7'd98;
  localparam logic [7:0]  LIGHT_THR_RST   = 8'd10;
  localparam logic [15:0] TEMP_THR_RST    = 16'd40;

  typedef enum logic [1:0] {
    REG_GYRO_WEIGHT, REG_LIGHT_THR, REG_TEMP_THR, REG_UNUSED
  } reg_idx_t;

  typedef enum logic [1:0] {EV_SCAN, EV_HEAT, EV_LIGHT, EV_BOTH} ev_class_t;

  typedef struct packed {
    logic [6:0]  gyro_weight;
    logic [7:0]  lux_limit;
    logic [15:0] heat_limit;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic        is_short;
    logic [15:0] mcand;
    logic [15:0] mplier;
  } mul_cmd_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] product;
  } mul_st_t;

  typedef enum logic [1:0] {DK_1000, DK_255, DK_100} div_dk_t;
  typedef enum logic [1:0] {DW_31, DW_22, DW_16, DW_15} div_dw_t;

  typedef struct packed {
    logic        start;
    div_dk_t     dk;
    div_dw_t     dw;
    logic [31:0] dividend;
  } div_cmd_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_st_t;

endpackage

>>> hdl/tlsf_chan_if.sv
// valid/ready channels for the sample and result beats
// no dependencies
interface tlsf_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x_sample;
  logic signed [15:0] gyro_rate;
  logic [15:0]        interval_ms;
  logic [7:0]         left_light;
  logic [7:0]         right_light;
  logic [15:0]        temperature;

  modport source (
    output valid, accel_x_sample, gyro_rate, interval_ms, left_light, right_light,
    temperature,
    input  ready
  );
  modport sink (
    input  valid, accel_x_sample, gyro_rate, interval_ms, left_light, right_light,
    temperature,
    output ready
  );
endinterface

interface tlsf_result_if;
  logic               valid;
  logic               ready;
  logic [7:0]         pointing_angle;
  logic [6:0]         confidence;
  logic [1:0]         event_class;
  logic signed [15:0] tilt_estimate;

  modport source (
    output valid, pointing_angle, confidence, event_class, tilt_estimate,
    input  ready
  );
  modport sink (
    input  valid, pointing_angle, confidence, event_class, tilt_estimate,
    output ready
  );
endinterface

>>> hdl/tilt_light_sensor_fusion.sv
// top level: sequencer over the serial multiplier and divider, result register
// depends on tlsf_pkg, tlsf_chan_if, tlsf_cfg, tlsf_mul, tlsf_div, assert_macros.svh
//
//   channel  | dir | handshake                   | payload
//   sample   | in  | valid/ready                 | accel, gyro, interval, lights, temp
//   result   | out | valid/ready                 | angle, confidence, class, tilt
//   apb      | in  | psel/penable/pwrite, pready | 3 registers at 0x0, 0x4, 0x8
//
// each item runs alone to its result, and sample ready rises together with result valid:
// twelve dependent serial operations, one bit a cycle in the shared multiplier
// and the shared constant divider (31, 22, 16 and 15 quotient bits, 7 or 16 product bits)
// synchronous reset sets tilt to zero and the registers to 98, 10 and 40
// a result waits in its register while the next item is computed; finishing an item
// stalls only while that register is still full
`include "assert_macros.svh"

module tilt_light_sensor_fusion (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlsf_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  tlsf_sample_if.sink                 sample,
  tlsf_result_if.source               result
);
  import tlsf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_M1, S_D1, S_M3, S_D3, S_M2, S_M4, S_D4, S_D5, S_M6, S_D6, S_M7, S_D7,
    S_FINISH
  } state_t;

  localparam logic [6:0]  MAX_WEIGHT  = 7'd100;
  localparam logic [15:0] ACCEL_SCALE = 16'd90;
  localparam logic [15:0] DIFF_SCALE  = 16'd90;
  localparam logic [15:0] CONF_SCALE  = 16'd100;

  function automatic logic [15:0] cond_neg(input logic neg, input logic [15:0] v);
    return neg ? (~v + 16'd1) : v;
  endfunction

  cfg_t     cfg;
  mul_cmd_t mul_cmd;
  mul_st_t  mul_st;
  div_cmd_t div_cmd;
  div_st_t  div_st;
  state_t   state;

  logic        sg_gx;
  logic        sg_ax;
  logic        sg_gp;
  logic [15:0] ax_mag;
  logic [7:0]  left_q;
  logic [7:0]  right_q;
  logic [15:0] temp_q;
  logic [15:0] term1;
  logic [15:0] tilt_state;
  logic [8:0]  tq;
  logic [6:0]  dq;
  logic [6:0]  conf_q;

  logic        out_valid;
  logic [7:0]  out_angle;
  logic [6:0]  out_conf;
  logic [1:0]  out_class;
  logic [15:0] out_tilt;

  logic [6:0]  gw_sat;
  logic [6:0]  wa;
  logic [15:0] gx_in_mag;
  logic [15:0] ax_in_mag;
  logic [15:0] q16;
  logic [15:0] gp_new;
  logic [15:0] gp_mag;
  logic [7:0]  ap_now;
  logic [15:0] tilt_new;
  logic [15:0] tilt_mag;
  logic        sg_diff;
  logic [7:0]  mag;
  logic signed [10:0] dterm;
  logic signed [10:0] tterm;
  logic signed [10:0] angle;
  logic [7:0]  angle_sat;
  ev_class_t   ev_class;
  logic        dark;
  logic        contrast;
  logic        cold;
  logic        hot;

  tlsf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tlsf_mul u_mul (
    .clk (clk),
    .rst (rst),
    .cmd (mul_cmd),
    .st  (mul_st)
  );

  tlsf_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .st  (div_st)
  );

  assign gw_sat    = (cfg.gyro_weight > MAX_WEIGHT) ? MAX_WEIGHT : cfg.gyro_weight;
  assign wa        = MAX_WEIGHT - gw_sat;
  assign gx_in_mag = cond_neg(sample.gyro_rate[15], sample.gyro_rate);
  assign ax_in_mag = cond_neg(sample.accel_x_sample[15], sample.accel_x_sample);
  assign q16       = div_st.quotient[15:0];
  assign gp_new    = tilt_state + cond_neg(sg_gx, q16);
  assign gp_mag    = cond_neg(gp_new[15], gp_new);
  assign ap_now    = mul_st.product[21:14];
  assign tilt_new  = term1 + cond_neg(sg_ax, q16);
  assign tilt_mag  = cond_neg(tilt_new[15], tilt_new);
  assign sg_diff   = left_q < right_q;
  assign mag       = sg_diff ? (right_q - left_q) : (left_q - right_q);

  always_comb begin
    dterm = sg_diff ? -$signed({4'd0, dq}) : $signed({4'd0, dq});
    tterm = tilt_state[15] ? -$signed({2'd0, tq}) : $signed({2'd0, tq});
    angle = 11'sd90 - dterm - tterm;
    if (angle < 11'sd0) begin
      angle_sat = 8'd0;
    end else if (angle > 11'sd180) begin
      angle_sat = 8'd180;
    end else begin
      angle_sat = angle[7:0];
    end
  end

  always_comb begin
    dark     = (left_q < cfg.lux_limit) && (right_q < cfg.lux_limit);
    contrast = mag > cfg.lux_limit;
    cold     = temp_q < cfg.heat_limit;
    hot      = temp_q > cfg.heat_limit;
    priority if (cold && dark) begin
      ev_class = EV_SCAN;
    end else if (hot && dark) begin
      ev_class = EV_HEAT;
    end else if (cold && contrast) begin
      ev_class = EV_LIGHT;
    end else if (hot && contrast) begin
      ev_class = EV_BOTH;
    end else begin
      ev_class = EV_SCAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mul_cmd    <= '0;
      div_cmd    <= '0;
      tilt_state <= '0;
      out_valid  <= 1'b0;
    end else begin
      mul_cmd.start <= 1'b0;
      div_cmd.start <= 1'b0;
      if (out_valid && result.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (sample.valid) begin
          sg_gx   <= sample.gyro_rate[15];
          sg_ax   <= sample.accel_x_sample[15];
          ax_mag  <= ax_in_mag;
          left_q  <= sample.left_light;
          right_q <= sample.right_light;
          temp_q  <= sample.temperature;
          mul_cmd <= '{1'b1, 1'b0, gx_in_mag, sample.interval_ms};
          state   <= S_M1;
        end
        S_M1: if (mul_st.done) begin
          div_cmd <= '{1'b1, DK_1000, DW_31, mul_st.product};
          state   <= S_D1;
        end
        S_D1: if (div_st.done) begin
          sg_gp   <= gp_new[15];
          mul_cmd <= '{1'b1, 1'b1, gp_mag, {9'd0, gw_sat}};
          state   <= S_M3;
        end
        S_M3: if (mul_st.done) begin
          div_cmd <= '{1'b1, DK_100, DW_22, mul_st.product};
          state   <= S_D3;
        end
        S_D3: if (div_st.done) begin
          term1   <= cond_neg(sg_gp, q16);
          mul_cmd <= '{1'b1, 1'b1, ax_mag, ACCEL_SCALE};
          state   <= S_M2;
        end
        S_M2: if (mul_st.done) begin
          mul_cmd <= '{1'b1, 1'b1, {8'd0, ap_now}, {9'd0, wa}};
          state   <= S_M4;
        end
        S_M4: if (mul_st.done) begin
          div_cmd <= '{1'b1, DK_100, DW_15, mul_st.product};
          state   <= S_D4;
        end
        S_D4: if (div_st.done) begin
          tilt_state <= tilt_new;
          div_cmd    <= '{1'b1, DK_100, DW_16, {16'd0, tilt_mag}};
          state      <= S_D5;
        end
        S_D5: if (div_st.done) begin
          tq      <= div_st.quotient[8:0];
          mul_cmd <= '{1'b1, 1'b1, {8'd0, mag}, DIFF_SCALE};
          state   <= S_M6;
        end
        S_M6: if (mul_st.done) begin
          div_cmd <= '{1'b1, DK_255, DW_15, mul_st.product};
          state   <= S_D6;
        end
        S_D6: if (div_st.done) begin
          dq      <= div_st.quotient[6:0];
          mul_cmd <= '{1'b1, 1'b1, {8'd0, mag}, CONF_SCALE};
          state   <= S_M7;
        end
        S_M7: if (mul_st.done) begin
          div_cmd <= '{1'b1, DK_255, DW_15, mul_st.product};
          state   <= S_D7;
        end
        S_D7: if (div_st.done) begin
          conf_q <= div_st.quotient[6:0];
          state  <= S_FINISH;
        end
        S_FINISH: if (!out_valid || result.ready) begin
          out_angle <= angle_sat;
          out_conf  <= conf_q;
          out_class <= ev_class;
          out_tilt  <= tilt_state;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sample.ready          = (state == S_IDLE);
  assign result.valid          = out_valid;
  assign result.pointing_angle = out_angle;
  assign result.confidence     = out_conf;
  assign result.event_class    = out_class;
  assign result.tilt_estimate  = out_tilt;

  `TLSF_ASSERT_IMPLY(a_idle_units, clk, rst, sample.ready,
    !(mul_st.busy || div_st.busy), "serial unit busy while taking a beat")
  `TLSF_ASSERT_IMPLY(a_one_unit, clk, rst, mul_st.busy, !div_st.busy,
    "multiplier and divider busy together")
  `TLSF_ASSERT_NEXT(a_tilt_hold, clk, rst, !(state == S_D4 && div_st.done),
    $stable(tilt_state), "tilt changed outside its update")

endmodule

>>> hdl/tlsf_cfg.sv
// apb-style register file: gyro weight, light and temperature thresholds
// depends on tlsf_pkg
module tlsf_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlsf_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output tlsf_pkg::cfg_t              cfg
);
  import tlsf_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gyro_weight <= GYRO_WEIGHT_RST;
      cfg.lux_limit   <= LIGHT_THR_RST;
      cfg.heat_limit  <= TEMP_THR_RST;
    end else if (wr) begin
      unique case (idx)
        REG_GYRO_WEIGHT: cfg.gyro_weight <= pwdata[6:0];
        REG_LIGHT_THR:   cfg.lux_limit   <= pwdata[7:0];
        REG_TEMP_THR:    cfg.heat_limit  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GYRO_WEIGHT: prdata = {25'd0, cfg.gyro_weight};
      REG_LIGHT_THR:   prdata = {24'd0, cfg.lux_limit};
      REG_TEMP_THR:    prdata = {16'd0, cfg.heat_limit};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

>>> hdl/tlsf_mul.sv
// bit-serial shift-add multiplier, one multiplier bit a cycle
// depends on tlsf_pkg
module tlsf_mul (
  input  logic               clk,
  input  logic               rst,
  input  tlsf_pkg::mul_cmd_t cmd,
  output tlsf_pkg::mul_st_t  st
);
  import tlsf_pkg::*;

  localparam logic [4:0] SHORT_STEPS = 5'd7;
  localparam logic [4:0] LONG_STEPS  = 5'd16;

  logic [15:0] a;
  logic [15:0] hi;
  logic [15:0] lo;
  logic [4:0]  cnt;
  logic        is_short;
  logic        busy;
  logic        done;
  logic [16:0] sum;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, a} : 17'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        a        <= cmd.mcand;
        hi       <= '0;
        lo       <= cmd.mplier;
        is_short <= cmd.is_short;
        cnt      <= cmd.is_short ? SHORT_STEPS : LONG_STEPS;
        busy     <= 1'b1;
      end else if (busy) begin
        hi  <= sum[16:1];
        lo  <= {sum[0], lo[15:1]};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign st.busy    = busy;
  assign st.done    = done;
  assign st.product = is_short ? {9'd0, hi, lo[15:9]} : {hi, lo};

endmodule

>>> hdl/tlsf_div.sv
// restoring divider by a constant, one quotient bit a cycle
// depends on tlsf_pkg
module tlsf_div (
  input  logic               clk,
  input  logic               rst,
  input  tlsf_pkg::div_cmd_t cmd,
  output tlsf_pkg::div_st_t  st
);
  import tlsf_pkg::*;

  logic [31:0] dreg;
  logic [9:0]  rem;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  div_dk_t     dk;
  logic [10:0] divisor;
  logic [10:0] trial;
  logic [10:0] reduced;
  logic        ge;
  logic [4:0]  steps;
  logic [31:0] aligned;

  always_comb begin
    unique case (dk)
      DK_1000: divisor = 11'd1000;
      DK_255:  divisor = 11'd255;
      DK_100:  divisor = 11'd100;
      default: divisor = 11'd1000;
    endcase
  end

  // dividend moved to the top of the shift register
  always_comb begin
    unique case (cmd.dw)
      DW_31: begin
        steps   = 5'd31;
        aligned = {cmd.dividend[30:0], 1'b0};
      end
      DW_22: begin
        steps   = 5'd22;
        aligned = {cmd.dividend[21:0], 10'd0};
      end
      DW_16: begin
        steps   = 5'd16;
        aligned = {cmd.dividend[15:0], 16'd0};
      end
      DW_15: begin
        steps   = 5'd15;
        aligned = {cmd.dividend[14:0], 17'd0};
      end
    endcase
  end

  assign trial   = {rem, dreg[31]};
  assign ge      = trial >= divisor;
  assign reduced = trial - divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        dreg <= aligned;
        rem  <= '0;
        dk   <= cmd.dk;
        cnt  <= steps;
        busy <= 1'b1;
      end else if (busy) begin
        dreg <= {dreg[30:0], ge};
        rem  <= ge ? reduced[9:0] : trial[9:0];
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign st.busy     = busy;
  assign st.done     = done;
  assign st.quotient = dreg;

endmodule

>>> dv/tilt_light_sensor_fusion_tb.sv
`timescale 1ns / 100ps
// self-checking bench for tilt_light_sensor_fusion: sample beats in, fused readings out
// depends on tlsf_pkg, tlsf_chan_if and the rtl top; predicts each reading and compares it

typedef struct packed {
  logic signed [15:0] accel_x_sample;
  logic signed [15:0] gyro_rate;
  logic [15:0]        interval_ms;
  logic [7:0]         left_light;
  logic [7:0]         right_light;
  logic [15:0]        temperature;
} sample_beat_t;

typedef struct packed {
  logic [7:0]         pointing_angle;
  logic [6:0]         confidence;
  logic [1:0]         event_class;
  logic signed [15:0] tilt_estimate;
} result_beat_t;

class tilt_fusion_scoreboard;
  tlsf_pkg::cfg_t     cfg;
  logic signed [15:0] tilt;
  result_beat_t       fused_due[$];
  int                 n_err;
  int                 n_in;
  int                 n_out;

  function new();
    cfg.gyro_weight = tlsf_pkg::GYRO_WEIGHT_RST;
    cfg.lux_limit   = tlsf_pkg::LIGHT_THR_RST;
    cfg.heat_limit  = tlsf_pkg::TEMP_THR_RST;
    tilt  = '0;
    n_err = 0;
    n_in  = 0;
    n_out = 0;
  endfunction

  function void write_reg(tlsf_pkg::reg_idx_t idx, logic [31:0] data);
    case (idx)
      tlsf_pkg::REG_GYRO_WEIGHT: cfg.gyro_weight = data[6:0];
      tlsf_pkg::REG_LIGHT_THR:   cfg.lux_limit   = data[7:0];
      tlsf_pkg::REG_TEMP_THR:    cfg.heat_limit  = data[15:0];
      default: ;
    endcase
  endfunction

  function int wrap16(int v);
    logic signed [15:0] lo;
    lo = v[15:0];
    return int'(lo);
  endfunction

  function void note_sample(sample_beat_t s);
    int ax, gx, dt, l, r, gw, gpath, apath, t, diff, mag, ang, conf, lt;
    bit dark, contrast, cold, hot;
    result_beat_t e;
    ax = s.accel_x_sample;
    gx = s.gyro_rate;
    dt = s.interval_ms;
    l  = s.left_light;
    r  = s.right_light;
    gw = (cfg.gyro_weight > 7'd100) ? 100 : int'(cfg.gyro_weight);
    gpath = wrap16(int'(tilt) + (gx * dt) / 1000);
    apath = (ax * 90) / 16384;
    t = wrap16((gw * gpath) / 100 + ((100 - gw) * apath) / 100);
    tilt = t[15:0];
    diff = l - r;
    mag  = (diff < 0) ? -diff : diff;
    ang  = (90 - (diff * 90) / 255) - t / 100;
    if (ang < 0) ang = 0;
    if (ang > 180) ang = 180;
    conf = (mag * 100) / 255;
    lt = cfg.lux_limit;
    dark     = (l < lt) && (r < lt);
    contrast = mag > lt;
    cold     = s.temperature < cfg.heat_limit;
    hot      = s.temperature > cfg.heat_limit;
    e.event_class = tlsf_pkg::EV_SCAN;
    if (cold && dark) e.event_class = tlsf_pkg::EV_SCAN;
    else if (hot && dark) e.event_class = tlsf_pkg::EV_HEAT;
    else if (cold && contrast) e.event_class = tlsf_pkg::EV_LIGHT;
    else if (hot && contrast) e.event_class = tlsf_pkg::EV_BOTH;
    e.pointing_angle = ang[7:0];
    e.confidence     = conf[6:0];
    e.tilt_estimate  = t[15:0];
    fused_due.push_back(e);
    n_in++;
  endfunction

  function void compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
      n_err++;
    end
  endfunction

  function void check_result(result_beat_t got);
    result_beat_t want;
    n_out++;
    if (fused_due.size() == 0) begin
      $display("%0t unexpected result beat: expected none, actual angle %0d tilt %0d",
               $time, got.pointing_angle, got.tilt_estimate);
      n_err++;
      return;
    end
    want = fused_due.pop_front();
    compare_field("pointing_angle", want.pointing_angle, got.pointing_angle);
    compare_field("confidence", want.confidence, got.confidence);
    compare_field("event_class", want.event_class, got.event_class);
    compare_field("tilt_estimate", want.tilt_estimate, got.tilt_estimate);
  endfunction
endclass

module tilt_light_sensor_fusion_tb;
  import tlsf_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 120;
  localparam int N_PHASES       = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite, pready;
  logic [tlsf_pkg::APB_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  int idle_cycles = 0;
  int n_settings  = 0;

  tlsf_sample_if sample_bus ();
  tlsf_result_if result_bus ();

  tilt_fusion_scoreboard board = new();

  tilt_light_sensor_fusion dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (sample_bus),
    .result  (result_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    result_beat_t got;
    if (!rst) begin
      if (sample_bus.valid && sample_bus.ready) begin
        board.note_sample({sample_bus.accel_x_sample, sample_bus.gyro_rate,
                           sample_bus.interval_ms, sample_bus.left_light,
                           sample_bus.right_light, sample_bus.temperature});
      end
      if (result_bus.valid && result_bus.ready) begin
        got.pointing_angle = result_bus.pointing_angle;
        got.confidence     = result_bus.confidence;
        got.event_class    = result_bus.event_class;
        got.tilt_estimate  = result_bus.tilt_estimate;
        board.check_result(got);
      end
    end
    if (rst || (sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
        || (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog expired with %0d readings outstanding", $time,
               board.fused_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int pick_gap(int zero_pct);
    int p;
    p = $urandom_range(0, 99);
    if (p < zero_pct) return 0;
    if (p < 88) return $urandom_range(1, 4);
    if (p < 97) return $urandom_range(5, 40);
    return $urandom_range(100, 300);
  endfunction

  // result side back-pressure
  initial begin
    int p;
    result_bus.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      p = $urandom_range(0, 99);
      result_bus.ready <= 1'b1;
      if (p < 70) repeat ($urandom_range(1, 8)) @(posedge clk);
      else if (p < 95) repeat ($urandom_range(9, 60)) @(posedge clk);
      else repeat ($urandom_range(200, 1500)) @(posedge clk);
      result_bus.ready <= 1'b0;
      repeat (pick_gap(0)) @(posedge clk);
    end
  end

  function automatic sample_beat_t mk(int ax, int gx, int dt, int l, int r, int t);
    sample_beat_t s;
    s.accel_x_sample = ax[15:0];
    s.gyro_rate      = gx[15:0];
    s.interval_ms    = dt[15:0];
    s.left_light     = l[7:0];
    s.right_light    = r[7:0];
    s.temperature    = t[15:0];
    return s;
  endfunction

  function automatic sample_beat_t rand_sample();
    sample_beat_t s;
    int p, lt, l, r, d;
    lt = board.cfg.lux_limit;
    p = $urandom_range(0, 9);
    if (p < 7) s.accel_x_sample = 16'($urandom);
    else if (p == 7) s.accel_x_sample = 16'sh8000;
    else if (p == 8) s.accel_x_sample = 16'sh7fff;
    else s.accel_x_sample = 16'($urandom_range(0, 2000) - 1000);
    p = $urandom_range(0, 9);
    if (p < 6) s.gyro_rate = 16'($urandom);
    else if (p < 8) s.gyro_rate = 16'($urandom_range(0, 1000) - 500);
    else if (p == 8) s.gyro_rate = 16'sh8000;
    else s.gyro_rate = 16'sh7fff;
    p = $urandom_range(0, 9);
    if (p < 6) s.interval_ms = 16'($urandom_range(0, 50));
    else if (p < 8) s.interval_ms = 16'($urandom);
    else if (p == 8) s.interval_ms = 16'd0;
    else s.interval_ms = 16'hffff;
    p = $urandom_range(0, 9);
    if (p < 4) begin
      l = $urandom_range(0, 255);
      r = $urandom_range(0, 255);
    end else if (p < 7 && lt > 0) begin
      l = $urandom_range(0, lt - 1);
      r = $urandom_range(0, lt - 1);
    end else begin
      l = $urandom_range(0, 255);
      d = $urandom_range(0, 2);
      d = lt + d - 1;
      r = $urandom_range(0, 1) ? l + d : l - d;
      if (r < 0) r = 0;
      if (r > 255) r = 255;
    end
    s.left_light  = l[7:0];
    s.right_light = r[7:0];
    p = $urandom_range(0, 9);
    d = $urandom_range(0, 2);
    if (p < 5) s.temperature = 16'($urandom);
    else if (p < 8) s.temperature = board.cfg.heat_limit + d[15:0] - 16'd1;
    else s.temperature = 16'($urandom_range(0, 100));
    return s;
  endfunction

  task automatic send_sample(input sample_beat_t s);
    int gap;
    sample_bus.valid          <= 1'b1;
    sample_bus.accel_x_sample <= s.accel_x_sample;
    sample_bus.gyro_rate      <= s.gyro_rate;
    sample_bus.interval_ms    <= s.interval_ms;
    sample_bus.left_light     <= s.left_light;
    sample_bus.right_light    <= s.right_light;
    sample_bus.temperature    <= s.temperature;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    gap = pick_gap(55);
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    sample_bus.valid <= 1'b0;
    @(posedge clk);
    while (board.fused_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic program_regs(input int gw, input int lt, input int tt);
    apb_write(REG_GYRO_WEIGHT, gw);
    apb_write(REG_LIGHT_THR, lt);
    apb_write(REG_TEMP_THR, tt);
    n_settings++;
  endtask

  initial begin
    sample_beat_t directed[$];
    int gw_list[6];
    int lt_list[6];
    int tt_list[6];
    gw_list = '{98, 100, 0, 127, 101, 50};
    lt_list = '{10, 0, 255, 20, 255, 0};
    tt_list = '{40, 0, 65535, 1000, 0, 65535};
    sample_bus.valid          <= 1'b0;
    sample_bus.accel_x_sample <= '0;
    sample_bus.gyro_rate      <= '0;
    sample_bus.interval_ms    <= '0;
    sample_bus.left_light     <= '0;
    sample_bus.right_light    <= '0;
    sample_bus.temperature    <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed beats under reset register values
    directed.push_back(mk(0, 0, 0, 0, 0, 0));
    directed.push_back(mk(32767, 0, 0, 0, 0, 100));
    directed.push_back(mk(-32768, 0, 0, 255, 0, 0));
    directed.push_back(mk(0, 32767, 65535, 0, 255, 100));
    directed.push_back(mk(0, -32768, 65535, 255, 255, 40));
    directed.push_back(mk(0, -32768, 65535, 128, 128, 65535));
    directed.push_back(mk(0, 1000, 1, 5, 9, 39));
    directed.push_back(mk(0, 0, 0, 20, 10, 41));
    directed.push_back(mk(0, 0, 0, 21, 10, 41));
    directed.push_back(mk(-1, -1, 999, 255, 245, 0));
    directed.push_back(mk(16384, 0, 0, 9, 9, 41));
    directed.push_back(mk(-16384, 0, 0, 10, 0, 65535));
    directed.push_back(mk(0, 32767, 65535, 200, 0, 0));
    directed.push_back(mk(0, 32767, 65535, 200, 0, 0));
    directed.push_back(mk(0, -32768, 65535, 0, 200, 0));
    directed.push_back(mk(0, -32768, 65535, 0, 200, 0));
    directed.push_back(mk(32767, 32767, 65535, 255, 255, 65535));
    directed.push_back(mk(-32768, -32768, 65535, 0, 0, 0));
    directed.push_back(mk(0, 0, 65535, 0, 0, 0));
    foreach (directed[i]) send_sample(directed[i]);
    wait_drained();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 6) program_regs(gw_list[ph], lt_list[ph], tt_list[ph]);
      else program_regs($urandom_range(0, 127), $urandom_range(0, 255), $urandom_range(0, 65535));
      if (ph == 0) apb_write(REG_UNUSED, $urandom);
      repeat (PHASE_ITEMS) begin
        send_sample(rand_sample());
        if ($urandom_range(0, 79) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    $display("covered %0d sample beats and %0d result beats", board.n_in, board.n_out);
    $display("across %0d register settings, gyro weight 0 to 127", n_settings);
    if (board.n_err == 0 && board.fused_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+hdl
hdl/tlsf_pkg.sv
hdl/tlsf_chan_if.sv
hdl/tlsf_cfg.sv
hdl/tlsf_mul.sv
hdl/tlsf_div.sv
hdl/tilt_light_sensor_fusion.sv
dv/tilt_light_sensor_fusion_tb.sv
